FILE: rtl/sha1_pkg.sv
// Shared constants, command and status types, and round functions for the SHA-1 engine.
package sha1_pkg;

	localparam int unsigned NumH = 5;
	localparam int unsigned NumW = 16;
	localparam int unsigned Rounds = 80;

	localparam logic [31:0] H0Init = 32'h67452301;
	localparam logic [31:0] H1Init = 32'hEFCDAB89;
	localparam logic [31:0] H2Init = 32'h98BADCFE;
	localparam logic [31:0] H3Init = 32'h10325476;
	localparam logic [31:0] H4Init = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;
	localparam logic [5:0] LastPos = 6'd63;
	localparam logic [2:0] LastLenByte = 3'd7;
	localparam logic [6:0] LastRound = 7'(Rounds - 1);
	localparam logic [2:0] LastWord = 3'(NumH - 1);

	typedef enum logic [1:0] {
		BSEL_IN,
		BSEL_PAD,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      byte_en;
		byte_sel_t byte_sel;
		logic      count_bits;
		logic [2:0] len_idx;
		logic      rounds_load;
		logic      round_en;
		logic [6:0] round_idx;
		logic      block_done;
		logic      msg_init;
		logic [2:0] word_sel;
	} cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} status_t;

	function automatic logic [1:0] round_phase(input logic [6:0] idx);
		logic [1:0] ph;
		if (idx < 7'd20) begin
			ph = 2'd0;
		end else if (idx < 7'd40) begin
			ph = 2'd1;
		end else if (idx < 7'd60) begin
			ph = 2'd2;
		end else begin
			ph = 2'd3;
		end
		return ph;
	endfunction

	function automatic logic [31:0] round_k(input logic [1:0] ph);
		logic [31:0] k;
		case (ph)
			2'd0: k = K0;
			2'd1: k = K1;
			2'd2: k = K2;
			default: k = K3;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] ph, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (ph)
			2'd0: f = (b & c) | (~b & d);
			2'd2: f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

FILE: rtl/sha1_hash_engine.sv
// An item that completes a 64-byte block starts compression: the 80 rounds run on one shared
// round unit, then the chaining update follows; no new item is taken until that is done.
// After an end item the engine writes pad bytes and the eight length bytes and compresses one
// or two more blocks, then shows the five digest words, one per cycle when taken.
// Reset is asynchronous and active low; it loads the initial hash values and clears the
// byte position and bit length at once, with no clearing pass.
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast
);

	sha1_pkg::cmd_t    cmd;
	sha1_pkg::status_t status;
	logic [31:0]       digest;
	logic [2:0]        out_idx;

	sha1_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_has_byte (s_tuser),
		.in_end      (s_tlast),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_idx     (out_idx),
		.out_last    (m_tlast),
		.status      (status),
		.cmd         (cmd)
	);

	sha1_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_byte (s_tdata),
		.status  (status),
		.digest  (digest)
	);

	assign m_tdata = {5'b00000, out_idx, digest};

endmodule

FILE: rtl/sha1_dp.sv
// Datapath: byte packing, message schedule window, round registers and chaining words.
module sha1_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sha1_pkg::cmd_t   cmd,
	input  logic [7:0]       in_byte,
	output sha1_pkg::status_t status,
	output logic [31:0]      digest
);

	logic [31:0] h_q [sha1_pkg::NumH];
	logic [31:0] w_q [sha1_pkg::NumW];
	logic [23:0] acc_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [5:0]  pos_q;
	logic [63:0] bits_q;

	logic [7:0]  byte_val;
	logic [31:0] packed_word;
	logic [31:0] sched_x;
	logic [31:0] sched_word;
	logic [31:0] w_next;
	logic        w_shift;
	logic [1:0]  phase;
	logic [31:0] t_sum;

	always_comb begin
		case (cmd.byte_sel)
			sha1_pkg::BSEL_IN:   byte_val = in_byte;
			sha1_pkg::BSEL_PAD:  byte_val = sha1_pkg::PadByte;
			sha1_pkg::BSEL_LEN:  byte_val = bits_q[{~cmd.len_idx, 3'b000} +: 8];
			default:             byte_val = 8'h00;
		endcase
	end

	assign packed_word = {acc_q, byte_val};
	assign sched_x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign sched_word = {sched_x[30:0], sched_x[31]};
	assign w_next = cmd.round_en ? sched_word : packed_word;
	assign w_shift = cmd.round_en || (cmd.byte_en && (pos_q[1:0] == 2'b11));

	assign phase = sha1_pkg::round_phase(cmd.round_idx);
	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(phase, b_q, c_q, d_q)
		+ e_q + sha1_pkg::round_k(phase) + w_q[0];

	always_ff @(posedge clk) begin
		if (cmd.byte_en) begin
			acc_q <= packed_word[23:0];
		end
		if (w_shift) begin
			for (int i = 0; i < sha1_pkg::NumW - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[sha1_pkg::NumW - 1] <= w_next;
		end
		if (cmd.rounds_load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= sha1_pkg::H0Init;
			h_q[1] <= sha1_pkg::H1Init;
			h_q[2] <= sha1_pkg::H2Init;
			h_q[3] <= sha1_pkg::H3Init;
			h_q[4] <= sha1_pkg::H4Init;
			pos_q <= '0;
			bits_q <= '0;
		end else if (cmd.msg_init) begin
			h_q[0] <= sha1_pkg::H0Init;
			h_q[1] <= sha1_pkg::H1Init;
			h_q[2] <= sha1_pkg::H2Init;
			h_q[3] <= sha1_pkg::H3Init;
			h_q[4] <= sha1_pkg::H4Init;
			pos_q <= '0;
			bits_q <= '0;
		end else begin
			if (cmd.block_done) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.byte_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.count_bits) begin
				bits_q <= bits_q + 64'd8;
			end
		end
	end

	always_comb begin
		case (cmd.word_sel)
			3'd0: digest = h_q[0];
			3'd1: digest = h_q[1];
			3'd2: digest = h_q[2];
			3'd3: digest = h_q[3];
			3'd4: digest = h_q[4];
			default: digest = '0;
		endcase
	end

	assign status.pos = pos_q;

endmodule

FILE: rtl/sha1_ctrl.sv
// Controller: sequences byte loading, padding, the 80 rounds and the digest output.
module sha1_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_has_byte,
	input  logic              in_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_idx,
	output logic              out_last,
	input  sha1_pkg::status_t status,
	output sha1_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t     state_q;
	state_t     ret_q;
	logic [6:0] round_q;
	logic [2:0] len_q;
	logic [2:0] word_q;
	logic       pad_q;

	logic accept;
	logic pos_last;
	logic pad_done;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_idx = word_q;
	assign out_last = (word_q == sha1_pkg::LastWord);
	assign pos_last = (status.pos == sha1_pkg::LastPos);
	assign pad_done = pad_q && (status.pos == sha1_pkg::LenPos);

	always_comb begin
		cmd = '0;
		cmd.byte_sel = sha1_pkg::BSEL_IN;
		cmd.len_idx = len_q;
		cmd.round_idx = round_q;
		cmd.word_sel = word_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_has_byte) begin
					cmd.byte_en = 1'b1;
					cmd.count_bits = 1'b1;
					cmd.rounds_load = pos_last;
				end
			end
			ST_PAD: begin
				if (!pad_done) begin
					cmd.byte_en = 1'b1;
					cmd.byte_sel = pad_q ? sha1_pkg::BSEL_ZERO : sha1_pkg::BSEL_PAD;
					cmd.rounds_load = pos_last;
				end
			end
			ST_LEN: begin
				cmd.byte_en = 1'b1;
				cmd.byte_sel = sha1_pkg::BSEL_LEN;
				cmd.rounds_load = (len_q == sha1_pkg::LastLenByte);
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
			end
			ST_FIN: begin
				cmd.block_done = 1'b1;
			end
			ST_OUT: begin
				cmd.msg_init = out_ready && out_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			round_q <= '0;
			len_q <= '0;
			word_q <= '0;
			pad_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pad_q <= 1'b0;
						if (in_has_byte && pos_last) begin
							state_q <= ST_COMP;
							round_q <= '0;
							ret_q <= in_end ? ST_PAD : ST_IDLE;
						end else if (in_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (pad_done) begin
						state_q <= ST_LEN;
						len_q <= '0;
					end else begin
						pad_q <= 1'b1;
						if (pos_last) begin
							state_q <= ST_COMP;
							round_q <= '0;
							ret_q <= ST_PAD;
						end
					end
				end
				ST_LEN: begin
					len_q <= len_q + 3'd1;
					if (len_q == sha1_pkg::LastLenByte) begin
						state_q <= ST_COMP;
						round_q <= '0;
						ret_q <= ST_OUT;
					end
				end
				ST_COMP: begin
					round_q <= round_q + 7'd1;
					if (round_q == sha1_pkg::LastRound) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ret_q;
					word_q <= '0;
				end
				ST_OUT: begin
					if (out_ready) begin
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							word_q <= word_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/sha1_checker.sv
// Port-level checker for the SHA-1 engine and its bind to the top level.
module sha1_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	a_no_input_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while digest words are pending");

	a_last_is_h4: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[34:32] == 3'd4))
		else $error("last digest word is not h4");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)))
		else $error("digest word index did not advance by one");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
		else $error("engine not back to idle after the last digest word");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (.*);
